>>> sv/swpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_pkg
// Shared types, constants and the word compare for the sorted word pair table.
// ----------------------------------------------------------------------------
package swpt_pkg;

    localparam int CAPACITY   = 32;
    localparam int WORD_CHARS = 8;

    localparam int WORD_W    = 64;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int FIELDS_W  = REQ_W + 2 * WORD_W;
    localparam int TDATA_W   = ((FIELDS_W + 7) / 8) * 8;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMP_CHARS = (WORD_CHARS < 8) ? WORD_CHARS : 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // compare outcomes
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    // cell operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic       capture;
        logic [1:0] op;
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= 8'h41 && c <= 8'h5A) begin
                r = c + 8'h20;
            end
            return r;
        end
    endfunction

    // case-folded compare from the top byte, stops at the first nul
    function automatic logic [1:0] word_cmp(input logic [WORD_W-1:0] a,
                                            input logic [WORD_W-1:0] b);
        logic       done;
        logic [1:0] res;
        logic [7:0] ca;
        logic [7:0] cb;
        begin
            done = 1'b0;
            res  = CMP_EQ;
            for (int k = 0; k < CMP_CHARS; k++) begin
                ca = fold_byte(a[WORD_W-1-8*k -: 8]);
                cb = fold_byte(b[WORD_W-1-8*k -: 8]);
                if (!done) begin
                    if (ca != cb) begin
                        res  = (ca < cb) ? CMP_LT : CMP_GT;
                        done = 1'b1;
                    end else if (ca == 8'h00) begin
                        done = 1'b1;
                    end
                end
            end
            return res;
        end
    endfunction

endpackage

>>> sv/sorted_word_pair_table.sv
`timescale 1ns / 1ps
// insert and delete: accept, then one shift of the cell chain once the output register is free
// lookup with no match returns not found; with a match the ring turns once
// one request is in flight at a time; lookup gives at most one result per cycle
// output backpressure stalls the chain only while a result waits in the output register
// reset (synchronous, active low) empties the table; entry contents are not cleared
// ----------------------------------------------------------------------------
// sorted_word_pair_table
// Bounded table of word pairs kept ordered by foreign word in a chain of cells.
// ----------------------------------------------------------------------------
module sorted_word_pair_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // req_type[1:0], native_word[65:2], foreign_word[129:66], zero fill above
    input  logic [swpt_pkg::TDATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // status[1:0], found_native[65:2], found_foreign[129:66], zero fill above
    output logic [swpt_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    localparam int CAP = swpt_pkg::CAPACITY;
    localparam int WW  = swpt_pkg::WORD_W;

    logic [1:0]                    r_state, n_state;
    logic [swpt_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [swpt_pkg::REQ_W-1:0]    r_req, n_req;
    logic [WW-1:0]                 r_nat_key, n_nat_key;
    logic [WW-1:0]                 r_frn_key, n_frn_key;
    logic [CAP-1:0]                r_mvec, n_mvec;
    logic [swpt_pkg::IDX_W-1:0]    r_step, n_step;
    logic                          r_out_valid, n_out_valid;
    logic [swpt_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [WW-1:0]                 r_out_nat, n_out_nat;
    logic [WW-1:0]                 r_out_frn, n_out_frn;
    logic                          r_out_last, n_out_last;

    swpt_pkg::t_cell_ctl           w_ctl;
    logic [CAP:0]                  w_chain;
    logic [CAP-1:0]                w_match;
    logic [WW-1:0]                 w_nat [CAP];
    logic [WW-1:0]                 w_frn [CAP];
    logic [WW-1:0]                 w_in_nat;
    logic [WW-1:0]                 w_in_frn;
    logic [swpt_pkg::REQ_W-1:0]    w_in_req;
    logic                          w_in_xfer;
    logic                          w_out_free;

    assign w_in_req  = i_s_tdata[swpt_pkg::REQ_W-1:0];
    assign w_in_nat  = i_s_tdata[swpt_pkg::REQ_W +: WW];
    assign w_in_frn  = i_s_tdata[swpt_pkg::REQ_W + WW +: WW];
    assign w_in_xfer = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [WW-1:0] w_prev_nat;
        logic [WW-1:0] w_prev_frn;
        if (g == 0) begin : g_head
            assign w_prev_nat = r_nat_key;
            assign w_prev_frn = r_frn_key;
        end else begin : g_body
            assign w_prev_nat = w_nat[g-1];
            assign w_prev_frn = w_frn[g-1];
        end

        swpt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key_nat  (w_in_nat),
            .i_key_frn  (w_in_frn),
            .i_new_nat  (r_nat_key),
            .i_new_frn  (r_frn_key),
            .i_prev_nat (w_prev_nat),
            .i_prev_frn (w_prev_frn),
            .i_next_nat (w_nat[(g+1) % CAP]),
            .i_next_frn (w_frn[(g+1) % CAP]),
            .i_valid    (r_count > swpt_pkg::COUNT_W'(g)),
            .i_head     (g == 0),
            .i_at_end   (r_count == swpt_pkg::COUNT_W'(g)),
            .i_chain    (w_chain[g]),
            .o_chain    (w_chain[g+1]),
            .o_match    (w_match[g]),
            .o_nat      (w_nat[g]),
            .o_frn      (w_frn[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_req        = r_req;
        n_nat_key    = r_nat_key;
        n_frn_key    = r_frn_key;
        n_mvec       = r_mvec;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_nat    = r_out_nat;
        n_out_frn    = r_out_frn;
        n_out_last   = r_out_last;
        w_ctl.capture = 1'b0;
        w_ctl.op      = swpt_pkg::OP_HOLD;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_ctl.capture = 1'b1;
                    n_req     = w_in_req;
                    n_nat_key = w_in_nat;
                    n_frn_key = w_in_frn;
                    n_state   = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = swpt_pkg::ST_OK;
                    n_out_nat    = '0;
                    n_out_frn    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                    case (r_req)
                        swpt_pkg::REQ_INSERT: begin
                            if (r_count == swpt_pkg::COUNT_W'(CAP)) begin
                                n_out_status = swpt_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = swpt_pkg::OP_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        swpt_pkg::REQ_DELETE: begin
                            w_ctl.op = swpt_pkg::OP_DELETE;
                            if (w_chain[CAP]) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_out_status = swpt_pkg::ST_NOT_FOUND;
                            end
                        end
                        swpt_pkg::REQ_LOOKUP: begin
                            if (|w_match) begin
                                // matches are sent while the ring turns
                                n_out_valid = r_out_valid && !i_m_tready;
                                n_mvec      = w_match;
                                n_step      = '0;
                                n_state     = S_SCAN;
                            end else begin
                                n_out_status = swpt_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_out_status = swpt_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_mvec[0] || w_out_free) begin
                    if (r_mvec[0]) begin
                        n_out_valid  = 1'b1;
                        n_out_status = swpt_pkg::ST_OK;
                        n_out_nat    = w_nat[0];
                        n_out_frn    = w_frn[0];
                        n_out_last   = (r_mvec[CAP-1:1] == '0);
                    end
                    w_ctl.op = swpt_pkg::OP_ROTATE;
                    n_mvec   = {1'b0, r_mvec[CAP-1:1]};
                    n_step   = r_step + 1'b1;
                    if (r_step == swpt_pkg::IDX_W'(CAP - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_nat_key    <= n_nat_key;
        r_frn_key    <= n_frn_key;
        r_mvec       <= n_mvec;
        r_step       <= n_step;
        r_out_status <= n_out_status;
        r_out_nat    <= n_out_nat;
        r_out_frn    <= n_out_frn;
        r_out_last   <= n_out_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(swpt_pkg::TDATA_W - swpt_pkg::FIELDS_W){1'b0}},
                         r_out_frn, r_out_nat, r_out_status};

endmodule

>>> sv/swpt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_cell
// One table slot: holds a word pair, compares it against the request key and
// takes data from its neighbors when the chain shifts.
// ----------------------------------------------------------------------------
module swpt_cell (
    input  logic                         i_clk,
    input  swpt_pkg::t_cell_ctl          i_ctl,
    input  logic [swpt_pkg::WORD_W-1:0]  i_key_nat,
    input  logic [swpt_pkg::WORD_W-1:0]  i_key_frn,
    input  logic [swpt_pkg::WORD_W-1:0]  i_new_nat,
    input  logic [swpt_pkg::WORD_W-1:0]  i_new_frn,
    input  logic [swpt_pkg::WORD_W-1:0]  i_prev_nat,
    input  logic [swpt_pkg::WORD_W-1:0]  i_prev_frn,
    input  logic [swpt_pkg::WORD_W-1:0]  i_next_nat,
    input  logic [swpt_pkg::WORD_W-1:0]  i_next_frn,
    input  logic                         i_valid,
    input  logic                         i_head,
    input  logic                         i_at_end,
    input  logic                         i_chain,
    output logic                         o_chain,
    output logic                         o_match,
    output logic [swpt_pkg::WORD_W-1:0]  o_nat,
    output logic [swpt_pkg::WORD_W-1:0]  o_frn
);

    logic [swpt_pkg::WORD_W-1:0] r_nat, n_nat;
    logic [swpt_pkg::WORD_W-1:0] r_frn, n_frn;
    logic                        r_gt;
    logic                        r_ge;
    logic                        r_eq;
    logic [1:0]                  w_cmp_frn;
    logic                        w_hit;

    assign w_cmp_frn = swpt_pkg::word_cmp(r_frn, i_key_frn);

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_gt <= (w_cmp_frn == swpt_pkg::CMP_GT);
            r_ge <= (w_cmp_frn != swpt_pkg::CMP_LT);
            r_eq <= (swpt_pkg::word_cmp(r_nat, i_key_nat) == swpt_pkg::CMP_EQ);
        end
        r_nat <= n_nat;
        r_frn <= n_frn;
    end

    always_comb begin
        n_nat = r_nat;
        n_frn = r_frn;
        w_hit = 1'b0;
        case (i_ctl.op)
            swpt_pkg::OP_INSERT: begin
                // the head slot only yields when its word is strictly greater than the key
                w_hit = ((i_head ? r_gt : r_ge) && i_valid) || i_at_end;
                if (i_chain) begin
                    n_nat = i_prev_nat;
                    n_frn = i_prev_frn;
                end else if (w_hit) begin
                    n_nat = i_new_nat;
                    n_frn = i_new_frn;
                end
            end
            swpt_pkg::OP_DELETE: begin
                w_hit = i_valid && r_eq;
                if (i_chain || w_hit) begin
                    n_nat = i_next_nat;
                    n_frn = i_next_frn;
                end
            end
            swpt_pkg::OP_ROTATE: begin
                n_nat = i_next_nat;
                n_frn = i_next_frn;
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    assign o_chain = i_chain || w_hit;
    assign o_match = i_valid && r_eq;
    assign o_nat   = r_nat;
    assign o_frn   = r_frn;

endmodule
